/* rtl/assert_macros.svh */
// Assertion helpers for the job phase attribution block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// property a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/jpta_pkg.sv */
// ----------------------------------------------------------------------------
// jpta_pkg
// Types and codes shared by the job phase time attribution block.
// ----------------------------------------------------------------------------
package jpta_pkg;
  localparam int NACC = 6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FINALIZED = 3'd1,
    ST_REGRESSED = 3'd2,
    ST_BAD_FIRST = 3'd3,
    ST_AFTER_END = 3'd4,
    ST_DUP_ARR   = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_COMPUTE = 3'd1;
  localparam logic [2:0] PH_COMM = 3'd2;
  localparam logic [2:0] PH_SYNC = 3'd3;
  localparam logic [2:0] PH_STRAG = 3'd4;
  localparam logic [2:0] PH_OTHER = 3'd5;
  localparam logic [2:0] PH_TERM = 3'd6;

  localparam logic [3:0] TC_ARRIVED = 4'd0;
  localparam logic [3:0] TC_WAITING = 4'd1;
  localparam logic [3:0] TC_ADMITTED = 4'd2;
  localparam logic [3:0] TC_COMP_START = 4'd3;
  localparam logic [3:0] TC_COMP_DONE = 4'd4;
  localparam logic [3:0] TC_COLL_START = 4'd5;
  localparam logic [3:0] TC_COLL_DONE = 4'd6;
  localparam logic [3:0] TC_SYNC_START = 4'd7;
  localparam logic [3:0] TC_STRAG_START = 4'd8;
  localparam logic [3:0] TC_STEP_DONE = 4'd9;
  localparam logic [3:0] TC_SUCCEEDED = 4'd10;
  localparam logic [3:0] TC_FAILED = 4'd11;
  localparam logic [3:0] TC_CANCELLED = 4'd12;

  typedef logic [NACC-1:0][63:0] acc_row_t;

  function automatic logic [2:0] phase_after(logic [2:0] cur, logic [3:0] code,
                                             logic coll);
    logic keep;
    logic [2:0] r;
    keep = (cur == PH_COMPUTE) || (cur == PH_STRAG);
    case (code)
      TC_ARRIVED, TC_WAITING: r = PH_WAIT;
      TC_ADMITTED, TC_COLL_DONE, TC_STEP_DONE: r = keep ? cur : PH_OTHER;
      TC_COMP_START: r = PH_COMPUTE;
      TC_COMP_DONE: r = coll ? PH_COMM : PH_SYNC;
      TC_COLL_START: r = keep ? cur : PH_COMM;
      TC_SYNC_START: r = PH_SYNC;
      TC_STRAG_START: r = PH_STRAG;
      TC_SUCCEEDED, TC_FAILED, TC_CANCELLED: r = PH_TERM;
      default: r = PH_OTHER;
    endcase
    return r;
  endfunction
endpackage

/* rtl/jpta_slot_mem.sv */
// ----------------------------------------------------------------------------
// jpta_slot_mem
// Slot table: phase, entry time and six accumulators per slot, one
// synchronous read port with registered data and one write port.
// ----------------------------------------------------------------------------
module jpta_slot_mem
  import jpta_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [2:0]    rphase,
  output logic [62:0]   rentry,
  output acc_row_t      racc,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [2:0]    wphase,
  input  logic [62:0]   wentry,
  input  acc_row_t      wacc
);
  logic [2:0]  phase_mem [SLOTS];
  logic [62:0] entry_mem [SLOTS];
  acc_row_t    acc_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      phase_mem[waddr] <= wphase;
      entry_mem[waddr] <= wentry;
      acc_mem[waddr] <= wacc;
    end
    rphase <= phase_mem[raddr];
    rentry <= entry_mem[raddr];
    racc <= acc_mem[raddr];
  end
endmodule

/* rtl/job_phase_time_attribution.sv */
// ----------------------------------------------------------------------------
// job_phase_time_attribution
// Per-job phase tracking with time accumulation per phase.
// ----------------------------------------------------------------------------
// channel   direction  handshake         fields
// command   in         start & !busy     op job_slot event_time transition_code
//                                         coll_flag
// result    out        result_valid      status slot_index ... last_of_run
//
// An event passes through S_IDLE, which issues the slot read on acceptance,
// and S_ECHK, which checks, writes the row back and registers the result.
// Finalize, unless rejected at once, first sweeps all slots checking overflow
// (S_CREAD reads, S_CCHK checks) and stops with one result if a slot would
// overflow; else it sweeps again, updating and emitting one result per slot.
// Reset clears the used/done flags and the global time state; the table
// itself needs no clearing. Results are not stalled.
// ----------------------------------------------------------------------------
module job_phase_time_attribution
  import jpta_pkg::*;
#(
  parameter int JOB_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [3:0]  job_slot,
  input  logic [62:0] event_time,
  input  logic [3:0]  transition_code,
  input  logic        coll_flag,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [3:0]  slot_index,
  output logic        slot_valid,
  output logic [2:0]  phase_now,
  output logic        is_terminal,
  output logic [63:0] wait_total,
  output logic [63:0] compute_total,
  output logic [63:0] comm_total,
  output logic [63:0] sync_total,
  output logic [63:0] straggler_total,
  output logic [63:0] other_total,
  output logic        last_of_run
);
  `include "assert_macros.svh"

  localparam int AW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam logic [AW:0] LAST = (AW+1)'(JOB_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EREAD = 6'b000010,
    S_ECHK  = 6'b000100,
    S_CREAD = 6'b001000,
    S_CCHK  = 6'b010000,
    S_DREAD = 6'b100000
  } state_t;

  state_t      state;
  logic [3:0]  cur_slot;
  logic [62:0] cur_time;
  logic [3:0]  cur_code;
  logic        cur_coll;
  logic [AW-1:0] idx;
  logic        dump_chk;
  logic [JOB_SLOTS-1:0] slot_used, slot_done;
  logic [62:0] last_seen_time;
  logic        seen_any, finalized_flag;

  logic [AW-1:0] raddr, waddr;
  logic [2:0]  rphase, wphase;
  logic [62:0] rentry, wentry;
  acc_row_t    racc, wacc;
  logic        we;

  jpta_slot_mem #(.SLOTS(JOB_SLOTS), .AW(AW)) u_mem (
    .clk, .raddr, .rphase, .rentry, .racc,
    .we, .waddr, .wphase, .wentry, .wacc
  );

  assign busy = (state != S_IDLE);

  logic [AW-1:0] eslot;
  assign eslot = AW'(cur_slot);
  assign raddr = (state == S_IDLE) ? AW'(job_slot) : idx;

  logic fin_reject;
  assign fin_reject = finalized_flag || (seen_any && event_time < last_seen_time);

  // shared interval arithmetic on the row just read
  logic [63:0] dur, acc_sel, acc_sum;
  logic        t_back, ovf, has_acc;
  always_comb begin
    t_back = cur_time < rentry;
    dur = {1'b0, cur_time - rentry};
    has_acc = rphase < 3'(NACC);
    acc_sel = has_acc ? racc[rphase[2:0]] : 64'd0;
    acc_sum = acc_sel + dur;
    ovf = has_acc && (acc_sum < acc_sel);
  end

  logic [AW-1:0] cslot;
  logic          cused, cdone;
  assign cslot = (state == S_ECHK) ? eslot : idx;
  assign cused = slot_used[cslot];
  assign cdone = slot_done[cslot];

  logic chk_ovf;
  assign chk_ovf = cused && !cdone && !t_back && ovf;

  logic is_term_code;
  assign is_term_code = (cur_code == TC_SUCCEEDED) || (cur_code == TC_FAILED) ||
                        (cur_code == TC_CANCELLED);

  always_comb begin
    we = 1'b0;
    waddr = cslot;
    wphase = rphase;
    wentry = cur_time;
    wacc = racc;
    if (state == S_ECHK && !finalized_flag && !(seen_any && cur_time < last_seen_time)) begin
      if (!cused) begin
        if (cur_code == TC_ARRIVED || is_term_code) begin
          we = 1'b1;
          wphase = is_term_code ? PH_TERM : PH_WAIT;
          wacc = '0;
        end
      end else if (!cdone && cur_code != TC_ARRIVED && !t_back && !ovf) begin
        we = 1'b1;
        if (has_acc) wacc[rphase] = acc_sum;
        wphase = phase_after(rphase, cur_code, cur_coll);
      end
    end else if (state == S_CCHK && !dump_chk && cused && !cdone) begin
      we = 1'b1;
      if (!t_back && has_acc) wacc[rphase] = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      slot_used <= '0;
      slot_done <= '0;
      last_seen_time <= '0;
      seen_any <= 1'b0;
      finalized_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          result_valid <= start && op && fin_reject;
          if (start) begin
            cur_slot <= job_slot;
            cur_time <= event_time;
            cur_code <= transition_code;
            cur_coll <= coll_flag;
            idx <= '0;
            if (op) begin
              if (fin_reject) begin
                status <= finalized_flag ? ST_FINALIZED : ST_REGRESSED;
                slot_index <= '0; slot_valid <= 1'b0; phase_now <= '0;
                is_terminal <= 1'b0; last_of_run <= 1'b1;
                {wait_total, compute_total, comm_total} <= '0;
                {sync_total, straggler_total, other_total} <= '0;
              end else begin
                dump_chk <= 1'b1;
                state <= S_CREAD;
              end
            end else if (32'(job_slot) < JOB_SLOTS) begin
              state <= S_ECHK;
            end
          end
        end
        S_ECHK: begin
          result_valid <= 1'b1;
          last_of_run <= 1'b1;
          slot_index <= cur_slot;
          state <= S_IDLE;
          if (finalized_flag) status <= ST_FINALIZED;
          else if (seen_any && cur_time < last_seen_time) status <= ST_REGRESSED;
          else if (!cused && !(cur_code == TC_ARRIVED || is_term_code))
            status <= ST_BAD_FIRST;
          else if (cused && cdone) status <= ST_AFTER_END;
          else if (cused && cur_code == TC_ARRIVED) status <= ST_DUP_ARR;
          else if (cused && t_back) status <= ST_REGRESSED;
          else if (cused && ovf) status <= ST_OVERFLOW;
          else status <= ST_OK;
          if (we) begin
            slot_used[eslot] <= 1'b1;
            slot_done[eslot] <= (wphase == PH_TERM);
            last_seen_time <= cur_time;
            seen_any <= 1'b1;
          end
          slot_valid <= cused || we;
          phase_now <= (cused || we) ? wphase : 3'd0;
          is_terminal <= (cused || we) ? (wphase == PH_TERM) : 1'b0;
          {other_total, straggler_total, sync_total, comm_total, compute_total,
           wait_total} <= (cused || we) ? wacc : '0;
        end
        S_CREAD: begin
          result_valid <= 1'b0;
          state <= S_CCHK;
        end
        S_CCHK: begin
          result_valid <= !dump_chk || chk_ovf;
          if (dump_chk) begin
            if (chk_ovf) begin
              status <= ST_OVERFLOW;
              slot_index <= '0; slot_valid <= 1'b0; phase_now <= '0;
              is_terminal <= 1'b0; last_of_run <= 1'b1;
              {wait_total, compute_total, comm_total} <= '0;
              {sync_total, straggler_total, other_total} <= '0;
              state <= S_IDLE;
            end else if ({1'b0, idx} == LAST) begin
              dump_chk <= 1'b0;
              idx <= '0;
              state <= S_CREAD;
            end else begin
              idx <= idx + 1'b1;
              state <= S_CREAD;
            end
          end else begin
            status <= ST_OK;
            slot_index <= 4'(idx);
            slot_valid <= cused;
            phase_now <= cused ? rphase : 3'd0;
            is_terminal <= cused ? cdone : 1'b0;
            {other_total, straggler_total, sync_total, comm_total, compute_total,
             wait_total} <= cused ? wacc : '0;
            last_of_run <= ({1'b0, idx} == LAST);
            if ({1'b0, idx} == LAST) begin
              last_seen_time <= cur_time;
              seen_any <= 1'b1;
              finalized_flag <= 1'b1;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_DREAD;
            end
          end
        end
        S_DREAD: begin
          result_valid <= 1'b0;
          state <= S_CCHK;
        end
        S_EREAD: begin
          result_valid <= 1'b0;
          state <= S_ECHK;
        end
        default: begin
          result_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_no_ready, clk, rst, result_valid && !last_of_run, busy)
  `ASSERT_NEXT(a_fin_sticks, clk, rst, finalized_flag, finalized_flag)
  `ASSERT_IMPL(a_done_used, clk, rst, 1'b1, (slot_done & ~slot_used) == '0)
endmodule
